FILE: design/jpsnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsnp_pkg
// Shared types, constants and helpers for the jump point neighbor pruner.
// ----------------------------------------------------------------------------
package jpsnp_pkg;

  // Grid geometry and derived sizes.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  // Probe cells read per prune request and candidate neighbors per request.
  localparam int NUM_PROBES = 4;
  localparam int PIDX_W     = $clog2(NUM_PROBES);
  localparam int NUM_CANDS  = 5;

  // Command queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request codes.
  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_PRUNE = 1'b1
  } jpsnp_req_t;

  typedef logic signed [7:0] jpsnp_coord_t;

  typedef struct packed {
    jpsnp_coord_t x;
    jpsnp_coord_t y;
  } jpsnp_point_t;

  // Input request as it arrives on the ports.
  typedef struct packed {
    jpsnp_req_t  req_type;
    logic [5:0]  node_x;
    logic [5:0]  node_y;
    logic [5:0]  parent_x;
    logic [5:0]  parent_y;
    logic        cell_walkable;
  } jpsnp_in_t;

  // One result.
  typedef struct packed {
    jpsnp_coord_t nbr_x;
    jpsnp_coord_t nbr_y;
    logic         nbr_valid;
    logic         last;
  } jpsnp_out_t;

  // Classified command held in the queue.
  typedef struct packed {
    logic                                is_prune;
    logic                                diag;
    logic                                wr_data;
    logic [NUM_PROBES-1:0]               probe_inb;
    logic [NUM_PROBES-1:0][ADDR_W-1:0]   probe_addr;
    jpsnp_point_t [NUM_CANDS-1:0]        cand;
  } jpsnp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jpsnp_q_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } jpsnp_back_stat_t;

  // Build a point from two coordinates.
  function automatic jpsnp_point_t mk_point(jpsnp_coord_t x, jpsnp_coord_t y);
    jpsnp_point_t p;
    p.x = x;
    p.y = y;
    return p;
  endfunction

  // True when the point lies inside the grid.
  function automatic logic in_grid(jpsnp_point_t p);
    int px;
    int py;
    px = int'($signed(p.x));
    py = int'($signed(p.y));
    return (px >= 0) && (py >= 0) && (px < GRID_WIDTH) && (py < GRID_HEIGHT);
  endfunction

  // Linear bitmap address of an in-grid point.
  function automatic logic [ADDR_W-1:0] cell_addr(jpsnp_point_t p);
    int lin;
    lin = int'($signed(p.y)) * GRID_WIDTH + int'($signed(p.x));
    return ADDR_W'(lin);
  endfunction

  // Sign of (a - b) as -1, 0 or +1.
  function automatic jpsnp_coord_t sign_step(logic [5:0] a, logic [5:0] b);
    jpsnp_coord_t s;
    if (a > b) begin
      s = 8'sd1;
    end else if (a < b) begin
      s = -8'sd1;
    end else begin
      s = 8'sd0;
    end
    return s;
  endfunction

endpackage

FILE: design/jps_neighbor_pruning_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jps_neighbor_pruning_top
// Jump point search neighbor pruning over a walkability bitmap.
// ----------------------------------------------------------------------------
//  Channel  | Ports                     | Handshake
//  ---------+---------------------------+----------------------------------
//  request  | start, busy, in_item      | taken when start && !busy
//  result   | out_valid, out_item       | one-cycle strobe, never stalled
//
// A write request is carried out by the back end once it is at the head of
// the queue and the back end is idle. A prune request goes from ST_IDLE
// through four bitmap reads on the single read port (ST_READ) and ST_LAST,
// which waits for the last read data, then ST_EMIT gives one result per
// cycle (one to five); each result reaches the ports in the cycle after it
// is formed. After reset the bitmap is swept to blocked, one cell a cycle,
// over all CELL_COUNT (4096) cells; busy stays high during that pass.
// busy is high whenever the two-entry queue is full. Results are never
// held off; each appears for exactly one cycle.
// ----------------------------------------------------------------------------
module jps_neighbor_pruning_top import jpsnp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  jpsnp_in_t  in_item,
  output logic       out_valid,
  output jpsnp_out_t out_item
);

  logic             push;
  jpsnp_cmd_t       push_cmd;
  jpsnp_cmd_t       q_head;
  jpsnp_q_stat_t    q_stat;
  jpsnp_back_stat_t back_stat;

  // Requests are refused while clearing or while the queue is full.
  assign busy = back_stat.clearing | q_stat.full;

  jpsnp_front u_front (
    .start      (start),
    .can_accept (!busy),
    .in_item    (in_item),
    .push       (push),
    .cmd        (push_cmd)
  );

  jpsnp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (back_stat.pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  jpsnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_stat    (q_stat),
    .stat      (back_stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // No results and no queued work during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> (!out_valid && q_stat.empty))
    else $error("activity during bitmap clearing");

  // Retiring a prune request is followed by its final result.
  a_prune_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (back_stat.pop && q_head.is_prune) |=> (out_valid && out_item.last))
    else $error("prune request retired without a final result");

  // An empty result always closes its request.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.nbr_valid) |-> out_item.last)
    else $error("empty result not marked final");

  // An accepted request is held in the queue on the next cycle.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !q_stat.empty)
    else $error("accepted request missing from queue");

endmodule

FILE: design/jpsnp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsnp_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module jpsnp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/jpsnp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsnp_front
// Accepts requests, works out the direction and builds the probe cells and
// candidate neighbors that the back end needs.
// ----------------------------------------------------------------------------
module jpsnp_front import jpsnp_pkg::*; (
  input  logic       start,
  input  logic       can_accept,
  input  jpsnp_in_t  in_item,
  output logic       push,
  output jpsnp_cmd_t cmd
);

  assign push = start && can_accept;

  // Classify the request and lay out probes and candidates.
  always_comb begin
    jpsnp_coord_t x;
    jpsnp_coord_t y;
    jpsnp_coord_t dx;
    jpsnp_coord_t dy;
    jpsnp_point_t [NUM_PROBES-1:0] pr;
    x  = jpsnp_coord_t'({2'b00, in_item.node_x});
    y  = jpsnp_coord_t'({2'b00, in_item.node_y});
    dx = sign_step(in_item.node_x, in_item.parent_x);
    dy = sign_step(in_item.node_y, in_item.parent_y);

    cmd          = '0;
    cmd.is_prune = (in_item.req_type == REQ_PRUNE);
    cmd.wr_data  = in_item.cell_walkable;
    pr           = '0;

    if (in_item.req_type == REQ_WRITE) begin
      // A write targets the node cell itself.
      pr[0] = mk_point(x, y);
    end else if ((dx != 8'sd0) && (dy != 8'sd0)) begin
      // Diagonal move.
      cmd.diag    = 1'b1;
      pr[0]       = mk_point(x, y + dy);
      pr[1]       = mk_point(x + dx, y);
      pr[2]       = mk_point(x - dx, y);
      pr[3]       = mk_point(x, y - dy);
      cmd.cand[0] = mk_point(x, y + dy);
      cmd.cand[1] = mk_point(x + dx, y);
      cmd.cand[2] = mk_point(x + dx, y + dy);
      cmd.cand[3] = mk_point(x - dx, y + dy);
      cmd.cand[4] = mk_point(x + dx, y - dy);
    end else if (dx == 8'sd0) begin
      // Vertical move, also taken when node and parent coincide.
      pr[0]       = mk_point(x, y + dy);
      pr[1]       = mk_point(x + 8'sd1, y);
      pr[2]       = mk_point(x - 8'sd1, y);
      cmd.cand[0] = mk_point(x, y + dy);
      cmd.cand[1] = mk_point(x + 8'sd1, y + dy);
      cmd.cand[2] = mk_point(x - 8'sd1, y + dy);
    end else begin
      // Horizontal move.
      pr[0]       = mk_point(x + dx, y);
      pr[1]       = mk_point(x, y + 8'sd1);
      pr[2]       = mk_point(x, y - 8'sd1);
      cmd.cand[0] = mk_point(x + dx, y);
      cmd.cand[1] = mk_point(x + dx, y + 8'sd1);
      cmd.cand[2] = mk_point(x + dx, y - 8'sd1);
    end

    // Bounds flags and addresses; the fourth probe only counts on a diagonal.
    for (int i = 0; i < NUM_PROBES; i++) begin
      cmd.probe_inb[i]  = in_grid(pr[i]);
      cmd.probe_addr[i] = cell_addr(pr[i]);
    end
    if (cmd.is_prune && !cmd.diag) begin
      cmd.probe_inb[NUM_PROBES-1] = 1'b0;
    end
  end

endmodule

FILE: design/jpsnp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsnp_queue
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module jpsnp_queue import jpsnp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jpsnp_cmd_t    push_cmd,
  input  logic          pop,
  output jpsnp_cmd_t    head,
  output jpsnp_q_stat_t stat
);

  jpsnp_cmd_t        slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QDEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + QPTR_W'(1);
    end
    return n;
  endfunction

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/jpsnp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpsnp_back
// Clears the bitmap after reset, executes cell writes, reads the probe cells
// of a prune request and emits the surviving neighbors one per cycle.
// ----------------------------------------------------------------------------
module jpsnp_back import jpsnp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  jpsnp_cmd_t       head,
  input  jpsnp_q_stat_t    q_stat,
  output jpsnp_back_stat_t stat,
  output logic             out_valid,
  output jpsnp_out_t       out_item
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_EMIT  = 5'b10000
  } jpsnp_state_t;

  jpsnp_state_t          state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [PIDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [PIDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [NUM_PROBES-1:0] open_r;
  logic [NUM_CANDS-1:0]  done_r, done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  jpsnp_out_t            out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic                  ram_rdata;

  logic [NUM_CANDS-1:0]  mask;
  logic [NUM_CANDS-1:0]  rem;
  logic [NUM_CANDS-1:0]  low;
  jpsnp_point_t          sel;

  jpsnp_ram #(
    .WIDTH (1),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Survivor mask from the open flags of the probe cells.
  always_comb begin
    logic a;
    logic b;
    logic c;
    logic d;
    a = open_r[0];
    b = open_r[1];
    c = open_r[2];
    d = open_r[3];
    if (head.diag) begin
      mask = {b & ~d, a & ~c, a | b, b, a};
    end else begin
      mask = {2'b00, a & ~c, a & ~b, a};
    end
  end

  // Lowest remaining survivor and its coordinates.
  always_comb begin
    rem = mask & ~done_r;
    low = rem & (~rem + NUM_CANDS'(1));
    sel = '0;
    for (int i = 0; i < NUM_CANDS; i++) begin
      if (low[i]) begin
        sel = head.cand[i];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    done_nxt      = done_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = head.probe_addr[0];
    ram_wdata     = head.wr_data;
    ram_re        = 1'b0;
    ram_raddr     = head.probe_addr[rd_idx_r];
    stat.clearing = 1'b0;
    stat.pop      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        // Sweep the bitmap to blocked, one cell a cycle.
        stat.clearing = 1'b1;
        ram_we        = 1'b1;
        ram_waddr     = clr_cnt_r;
        ram_wdata     = 1'b0;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_stat.empty) begin
          if (!head.is_prune) begin
            // Cell write; cells outside the grid are dropped.
            ram_we   = head.probe_inb[0];
            stat.pop = 1'b1;
          end else begin
            rd_idx_nxt = '0;
            done_nxt   = '0;
            state_nxt  = ST_READ;
          end
        end
      end
      ST_READ: begin
        // One probe read per cycle.
        ram_re       = 1'b1;
        pend_nxt     = 1'b1;
        pend_idx_nxt = rd_idx_r;
        rd_idx_nxt   = rd_idx_r + PIDX_W'(1);
        if (rd_idx_r == PIDX_W'(NUM_PROBES - 1)) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        // Last probe data lands this cycle.
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (rem == '0) begin
          // No survivor: a single empty, final result.
          out_item_nxt = '{nbr_x: '0, nbr_y: '0, nbr_valid: 1'b0, last: 1'b1};
          stat.pop     = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          out_item_nxt.nbr_x     = sel.x;
          out_item_nxt.nbr_y     = sel.y;
          out_item_nxt.nbr_valid = 1'b1;
          out_item_nxt.last      = ((rem & ~low) == '0);
          done_nxt               = done_r | low;
          if ((rem & ~low) == '0) begin
            stat.pop  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: probe flags and the result word.
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    out_item_r <= out_item_nxt;
    if (pend_r) begin
      open_r[pend_idx_r] <= ram_rdata & head.probe_inb[pend_idx_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
